>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)

`define ASSERT_ANY(lbl, clk, prop, msg)

`endif

`endif

>>> sv/swm_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window maximum package
// Shared types and fixed widths of the sliding window maximum block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

    // Width of the result value port and of the window length register.
    localparam int OUT_WIDTH = 32;
    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] LEN_RESET = 7'd1;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic advance;   // shift the chain and take in the new sample
        logic flush;     // drop every entry at the end of a stream
    } t_cell_ctl;

endpackage

>>> sv/swm_cell.sv
// ---------------------------------------------------------------------------
// Window cell
// Holds the sample of one age in the window and whether it is still a
// candidate for the maximum. On each beat it takes its neighbor's entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int LEN_W        = 7,
    parameter int INDEX        = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swm_pkg::t_cell_ctl      i_ctl,
    input  logic [LEN_W-1:0]        i_len,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_prev_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_prev_value,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_value
);

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_value;
    logic                    w_expired;
    logic                    w_dominated;

    // After the shift this cell holds a sample that is INDEX beats old.
    assign w_expired   = (LEN_W'(INDEX) >= i_len);
    // A newer strictly larger sample can never be the maximum again.
    assign w_dominated = ($signed(i_prev_value) < $signed(i_sample));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_prev_valid && !w_expired && !w_dominated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

>>> sv/swm_front_tree.sv
// ---------------------------------------------------------------------------
// Front select tree
// Registered binary tree that picks the valid cell of greatest age, which
// is the front of the candidate queue and so the window maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_front_tree #(
    parameter int N            = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic [N-1:0]                   i_valid,
    input  logic [N-1:0][SAMPLE_WIDTH-1:0] i_value,
    output logic                           o_valid,
    output logic [SAMPLE_WIDTH-1:0]        o_value
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
    localparam int NPAD   = 1 << LEVELS;

    logic                    w_leaf_valid [0:NPAD-1];
    logic [SAMPLE_WIDTH-1:0] w_leaf_value [0:NPAD-1];
    logic                    r_node_valid [1:NPAD-1];
    logic [SAMPLE_WIDTH-1:0] r_node_value [1:NPAD-1];

    genvar g;

    for (g = 0; g < NPAD; g++) begin : g_leaf
        if (g < N) begin : g_real
            assign w_leaf_valid[g] = i_valid[g];
            assign w_leaf_value[g] = i_value[g];
        end else begin : g_pad
            assign w_leaf_valid[g] = 1'b0;
            assign w_leaf_value[g] = '0;
        end
    end

    // Node k covers its children 2k and 2k+1; the right child holds the older
    // cells, so it wins whenever it has a valid entry.
    for (g = 1; g < NPAD; g++) begin : g_node
        if (2 * g >= NPAD) begin : g_from_leaf
            always_ff @(posedge i_clk) begin
                r_node_valid[g] <= w_leaf_valid[2*g-NPAD] | w_leaf_valid[2*g+1-NPAD];
                r_node_value[g] <= w_leaf_valid[2*g+1-NPAD] ? w_leaf_value[2*g+1-NPAD]
                                                             : w_leaf_value[2*g-NPAD];
            end
        end else begin : g_from_node
            always_ff @(posedge i_clk) begin
                r_node_valid[g] <= r_node_valid[2*g] | r_node_valid[2*g+1];
                r_node_value[g] <= r_node_valid[2*g+1] ? r_node_value[2*g+1]
                                                       : r_node_value[2*g];
            end
        end
    end

    assign o_valid = r_node_valid[1];
    assign o_value = r_node_value[1];

endmodule

>>> sv/sliding_window_maximum.sv
// ---------------------------------------------------------------------------
// Sliding window maximum
// Emits the largest of the last window_len signed samples once the window
// has filled, using a shifting chain of candidate cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (i_valid / o_stall) carry one sample and an end marker.
//   Result beats (o_valid / i_stall) carry the window maximum and a flag on
//   the result of the end-marker beat. A beat gives no result while fewer
//   than window_len samples have been seen since reset or the last end marker.
//   The window length is written on the config channel, which is always
//   ready; values of zero act as one and values above WINDOW_MAX saturate.
//   A result passes from the candidate cells through each level of the
//   registered front select tree into the output register. Only one input
//   beat is in flight: o_stall holds further beats until the last one has
//   passed the tree and its result, if any, is in the output register.
//   The result sits in an output register, so the next sample is taken while
//   a stalled result waits; a further result holds the input stalled until
//   the output register is free. Reset empties the window and sets the
//   window length to one. The end marker empties the window after its result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_maximum #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [SAMPLE_WIDTH-1:0]             i_sample,
    input  logic                                i_end_of_stream,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [swm_pkg::OUT_WIDTH-1:0]       o_window_max,
    output logic                                o_last_result,
    // Config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]       i_cfg_data
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (LEN_W > swm_pkg::CFG_WIDTH) ? LEN_W : swm_pkg::CFG_WIDTH;
    localparam int LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(LEVELS + 1);

    logic [swm_pkg::CFG_WIDTH-1:0]      r_window_len;
    logic [LEN_W-1:0]                   r_filled;
    logic                               r_busy;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_produce;
    logic                               r_eos;
    logic                               r_out_valid;
    logic [swm_pkg::OUT_WIDTH-1:0]      r_out_max;
    logic                               r_out_last;

    logic [CMP_W-1:0]                   w_len_ext;
    logic [LEN_W-1:0]                   w_len;
    logic [LEN_W-1:0]                   w_filled_next;
    logic                               w_accept;
    logic                               w_finish;
    logic                               w_load;
    logic                               w_root_valid;
    logic [SAMPLE_WIDTH-1:0]            w_root_value;
    swm_pkg::t_cell_ctl                 w_ctl;

    logic [WINDOW_MAX-1:0]                    c_valid;
    logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0]  c_value;

    // Effective window length, clamped to 1..WINDOW_MAX.
    always_comb begin
        w_len_ext = CMP_W'(r_window_len);
        if (r_window_len == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_ext > CMP_W'(WINDOW_MAX)) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = LEN_W'(w_len_ext);
        end
    end

    assign w_filled_next = (r_filled < LEN_W'(WINDOW_MAX)) ? r_filled + LEN_W'(1) : r_filled;

    assign w_accept = i_valid && !r_busy;
    // The tree root is settled once the count has run down to zero.
    assign w_finish = r_busy && (r_cnt == '0) && (!r_produce || !r_out_valid || !i_stall);
    assign w_load   = w_finish && r_produce && w_root_valid;

    assign w_ctl.advance = w_accept;
    assign w_ctl.flush   = w_finish && r_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swm_pkg::LEN_RESET;
            r_filled     <= '0;
            r_busy       <= 1'b0;
            r_cnt        <= '0;
            r_produce    <= 1'b0;
            r_eos        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_len <= i_cfg_data;
            end
            if (w_accept) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_W'(LEVELS);
                r_produce <= (w_filled_next >= w_len);
                r_eos     <= i_end_of_stream;
                r_filled  <= i_end_of_stream ? '0 : w_filled_next;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && (r_cnt != '0)) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_max  <= swm_pkg::OUT_WIDTH'(w_root_value);
            r_out_last <= r_eos;
        end
    end

    genvar g;

    for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_head
            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .LEN_W        (LEN_W),
                .INDEX        (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_len        (w_len),
                .i_sample     (i_sample),
                .i_prev_valid (1'b1),
                .i_prev_value (i_sample),
                .o_valid      (c_valid[g]),
                .o_value      (c_value[g])
            );
        end else begin : g_body
            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .LEN_W        (LEN_W),
                .INDEX        (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_len        (w_len),
                .i_sample     (i_sample),
                .i_prev_valid (c_valid[g-1]),
                .i_prev_value (c_value[g-1]),
                .o_valid      (c_valid[g]),
                .o_value      (c_value[g])
            );
        end
    end

    swm_front_tree #(
        .N            (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_valid (c_valid),
        .i_value (c_value),
        .o_valid (w_root_valid),
        .o_value (w_root_value)
    );

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_window_max  = r_out_max;
    assign o_last_result = r_out_last;
    assign o_cfg_ready   = 1'b1;

    `ASSERT_SYNC(a_accept_holds_input, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "sample beat taken while another is in flight")
    `ASSERT_SYNC(a_idle_count_zero, i_clk, i_rst_n, !r_busy |-> (r_cnt == '0), "settle count running while idle")
    `ASSERT_SYNC(a_count_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(LEVELS), "settle count beyond tree depth")
    `ASSERT_SYNC(a_load_shows_result, i_clk, i_rst_n, w_load |=> o_valid, "loaded result not shown")

endmodule
